// ----- rtl/core/lfuct_pkg.sv -----
// Shared types and constants for the LFU cache table.
// This package stands alone; every other file in rtl/core imports it.
package lfuct_pkg;

	// Table geometry
	localparam int CAPACITY    = 16;
	localparam int COUNT_WIDTH = 16;
	localparam int SLOT_W      = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int RANK_W      = SLOT_W;
	localparam int OCC_W       = $clog2(CAPACITY + 1);
	localparam int CAP_W       = 5;
	localparam int CMP_W       = (OCC_W > CAP_W) ? OCC_W : CAP_W;

	// Victim search: groups reduced in the lookup cycle, groups merged in the update cycle
	localparam int GROUP_SIZE  = 4;
	localparam int GROUPS      = (CAPACITY + GROUP_SIZE - 1) / GROUP_SIZE;

	localparam logic [CAP_W-1:0]       CAP_RESET = CAP_W'(16);
	localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;
	localparam logic [31:0]            MISS_VALUE = '1;

	// action codes
	localparam logic ACT_GET = 1'b0;
	localparam logic ACT_SET = 1'b1;

	typedef struct packed {
		logic               action;
		logic signed [31:0] lookup_key;
		logic signed [31:0] write_value;
	} in_word_t;

	typedef struct packed {
		logic               hit;
		logic signed [31:0] read_value;
		logic               evicted;
		logic signed [31:0] evicted_key;
	} out_word_t;

	// controller -> datapath
	typedef struct packed {
		logic load_in;
		logic look;
		logic update;
	} cmd_t;

	// one contender in the victim search
	typedef struct packed {
		logic                   valid;
		logic [COUNT_WIDTH-1:0] count;
		logic [RANK_W-1:0]      rank;
		logic [SLOT_W-1:0]      idx;
	} cand_t;

	// a beats b: lower count, or equal count and older
	function automatic logic cand_better(cand_t a, cand_t b);
		logic r;
		r = a.valid && (!b.valid || (a.count < b.count) ||
			((a.count == b.count) && (a.rank > b.rank)));
		return r;
	endfunction

endpackage

// ----- rtl/core/lfuct_ctrl.sv -----
// Sequencer for the LFU cache table: handshakes and datapath commands.
// Depends on lfuct_pkg (cmd_t).
module lfuct_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	output logic               out_valid,
	input  logic               out_ready,
	output lfuct_pkg::cmd_t    cmd
);
	import lfuct_pkg::*;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_LOOK = 2'd1;
	localparam logic [1:0] ST_UPD  = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_d;
	logic       out_valid_q;
	logic       out_free;
	logic       accept;

	assign out_free = !out_valid_q || out_ready;
	assign in_ready = (state_q == ST_IDLE) || ((state_q == ST_UPD) && out_free);
	assign accept   = in_valid && in_ready;

	assign cmd.load_in = accept;
	assign cmd.look    = (state_q == ST_LOOK);
	assign cmd.update  = (state_q == ST_UPD) && out_free;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept)
					state_d = ST_LOOK;
			end
			ST_LOOK: begin
				state_d = ST_UPD;
			end
			ST_UPD: begin
				if (out_free)
					state_d = accept ? ST_LOOK : ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.update)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

endmodule

// ----- rtl/core/lfuct_dpath.sv -----
// Datapath of the LFU cache table: entry storage, key match, victim search, update.
// Depends on lfuct_pkg (word types, cmd_t, cand_t, cand_better).
module lfuct_dpath (
	input  logic                        clk,
	input  logic                        arst_n,
	input  lfuct_pkg::cmd_t             cmd,
	input  lfuct_pkg::in_word_t         in_word,
	input  logic                        cfg_we,
	input  logic [lfuct_pkg::CAP_W-1:0] cfg_data,
	output lfuct_pkg::out_word_t        out_word
);
	import lfuct_pkg::*;

	// entry storage
	logic [CAPACITY-1:0]    valid_q;
	logic [31:0]            key_q   [CAPACITY];
	logic [31:0]            value_q [CAPACITY];
	logic [COUNT_WIDTH-1:0] cnt_q   [CAPACITY];
	logic [RANK_W-1:0]      rank_q  [CAPACITY];
	logic [OCC_W-1:0]       occ_q;
	logic [CAP_W-1:0]       cap_q;

	in_word_t  in_q;
	out_word_t out_q;

	// lookup stage
	logic [CAPACITY-1:0] match;
	logic                hit_c;
	logic [SLOT_W-1:0]   hit_idx_c;
	cand_t               grp_c  [GROUPS];
	logic                hit_s1;
	logic [SLOT_W-1:0]   hit_idx_s1;
	cand_t               grp_s1 [GROUPS];

	// update stage
	cand_t                  vict;
	logic [CMP_W-1:0]       cap_x;
	logic [CMP_W-1:0]       cap_eff;
	logic                   cap_zero;
	logic                   full;
	logic                   is_set;
	logic                   do_touch;
	logic                   do_evict;
	logic                   do_insert;
	logic [RANK_W-1:0]      hit_rank;
	logic [CAPACITY-1:0]    valid_after;
	logic                   free_any;
	logic [SLOT_W-1:0]      free_idx;
	logic [CAPACITY-1:0]    valid_nx;
	logic [RANK_W-1:0]      rank_nx [CAPACITY];
	logic [COUNT_WIDTH-1:0] cnt_nx  [CAPACITY];
	out_word_t              res;

	// key compare and first level of the victim search
	always_comb begin
		cand_t c;
		int    n;
		hit_c     = 1'b0;
		hit_idx_c = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			match[i] = valid_q[i] && (key_q[i] == in_q.lookup_key);
			if (match[i]) begin
				hit_c     = 1'b1;
				hit_idx_c = SLOT_W'(i);
			end
		end
		for (int g = 0; g < GROUPS; g++) begin
			grp_c[g] = '0;
			for (int k = 0; k < GROUP_SIZE; k++) begin
				n = g * GROUP_SIZE + k;
				if (n < CAPACITY) begin
					c.valid = valid_q[n];
					c.count = cnt_q[n];
					c.rank  = rank_q[n];
					c.idx   = SLOT_W'(n);
					if (cand_better(c, grp_c[g]))
						grp_c[g] = c;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in)
			in_q <= in_word;
		if (cmd.look) begin
			hit_s1     <= hit_c;
			hit_idx_s1 <= hit_idx_c;
			for (int g = 0; g < GROUPS; g++)
				grp_s1[g] <= grp_c[g];
		end
	end

	// final victim pick and next table state
	always_comb begin
		vict = grp_s1[0];
		for (int g = 1; g < GROUPS; g++)
			if (cand_better(grp_s1[g], vict))
				vict = grp_s1[g];

		cap_x    = CMP_W'(cap_q);
		cap_eff  = (cap_x > CMP_W'(CAPACITY)) ? CMP_W'(CAPACITY) : cap_x;
		cap_zero = (cap_q == '0);
		full     = (CMP_W'(occ_q) >= cap_eff);
		is_set   = (in_q.action == ACT_SET);
		hit_rank = rank_q[hit_idx_s1];

		do_touch = hit_s1 && (!is_set || !cap_zero);
		do_evict = is_set && !hit_s1 && !cap_zero && full && vict.valid;

		valid_after = valid_q;
		if (do_evict)
			valid_after[vict.idx] = 1'b0;
		free_any = 1'b0;
		free_idx = '0;
		for (int i = CAPACITY - 1; i >= 0; i--) begin
			if (!valid_after[i]) begin
				free_any = 1'b1;
				free_idx = SLOT_W'(i);
			end
		end
		do_insert = is_set && !hit_s1 && !cap_zero && free_any;

		valid_nx = valid_after;
		for (int i = 0; i < CAPACITY; i++) begin
			rank_nx[i] = rank_q[i];
			cnt_nx[i]  = cnt_q[i];
			if (do_touch) begin
				if (SLOT_W'(i) == hit_idx_s1) begin
					rank_nx[i] = '0;
					if (cnt_q[i] != COUNT_MAX)
						cnt_nx[i] = cnt_q[i] + 1'b1;
				end else if (valid_q[i] && (rank_q[i] < hit_rank)) begin
					rank_nx[i] = rank_q[i] + 1'b1;
				end
			end
			if (do_insert) begin
				// the eviction closes the victim's rank gap, the insert shifts all by one
				if (SLOT_W'(i) == free_idx) begin
					rank_nx[i]  = '0;
					cnt_nx[i]   = COUNT_WIDTH'(1);
					valid_nx[i] = 1'b1;
				end else if (valid_after[i] && !(do_evict && (rank_q[i] > vict.rank))) begin
					rank_nx[i] = rank_q[i] + 1'b1;
				end
			end
		end

		res.hit         = hit_s1;
		res.read_value  = '0;
		if (!is_set)
			res.read_value = hit_s1 ? value_q[hit_idx_s1] : MISS_VALUE;
		res.evicted     = do_evict;
		res.evicted_key = do_evict ? key_q[vict.idx] : '0;
	end

	always_ff @(posedge clk) begin
		if (cmd.update) begin
			out_q <= res;
			for (int i = 0; i < CAPACITY; i++) begin
				rank_q[i] <= rank_nx[i];
				cnt_q[i]  <= cnt_nx[i];
			end
			if (do_touch && is_set)
				value_q[hit_idx_s1] <= in_q.write_value;
			if (do_insert) begin
				key_q[free_idx]   <= in_q.lookup_key;
				value_q[free_idx] <= in_q.write_value;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			occ_q   <= '0;
			cap_q   <= CAP_RESET;
		end else begin
			if (cfg_we)
				cap_q <= cfg_data;
			if (cmd.update) begin
				valid_q <= valid_nx;
				occ_q   <= occ_q + OCC_W'(do_insert) - OCC_W'(do_evict);
			end
		end
	end

	assign out_word = out_q;

endmodule

// ----- rtl/core/lfu_cache_table_unit.sv -----
// Top level of the LFU cache table (LFU replacement, LRU tie-break).
// Depends on lfuct_pkg, lfuct_ctrl and lfuct_dpath.
//
// Usage
//   in channel  : in_valid/in_ready carry one request word (get or set).
//   out channel : out_valid/out_ready carry one result word per request.
//   cfg port    : cfg_we/cfg_data write capacity_in_use; write only while idle.
//
// Operation
//   Each word passes through a lookup state (16-way key
//   compare plus the in-group stage of the min-count / oldest-age
//   search) and an update state (final victim pick, table write).
//   The request word is registered on accept, the lookup results at
//   the end of the lookup state, and the result in the output register
//   at the end of the update state. A new request is taken in the
//   update state of the previous one, once the output register is free.
//
// Reset clears all valid marks, the occupancy count and the sequencer,
//   and sets capacity_in_use to 16. Keys, values and counts are not cleared.
// Stall: a result waits in the output register; the next request runs its
//   lookup, then holds in update until out_ready frees the register.
module lfu_cache_table_unit (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  lfuct_pkg::in_word_t         in_word,
	output logic                        out_valid,
	input  logic                        out_ready,
	output lfuct_pkg::out_word_t        out_word,
	input  logic                        cfg_we,
	input  logic [lfuct_pkg::CAP_W-1:0] cfg_data
);
	import lfuct_pkg::*;

	cmd_t cmd;

	// sequencer: owns both handshakes
	lfuct_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd)
	);

	// table storage, search and result register
	lfuct_dpath u_dpath (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.in_word  (in_word),
		.cfg_we   (cfg_we),
		.cfg_data (cfg_data),
		.out_word (out_word)
	);

endmodule

// ----- rtl/core/lfuct_chk.sv -----
// Port-level checker for the LFU cache table, bound to the top level.
// Depends on lfuct_pkg (word types).
module lfuct_chk (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 in_valid,
	input logic                 in_ready,
	input lfuct_pkg::in_word_t  in_word,
	input logic                 out_valid,
	input logic                 out_ready,
	input lfuct_pkg::out_word_t out_word
);
	import lfuct_pkg::*;

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_word))
		else $error("result word changed while stalled");

	// one word at a time through the lookup cycle
	a_no_double: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("request taken during lookup");

	// a fresh result goes valid only after an accept has passed through the lookup and update states
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && in_ready, 3))
		else $error("result without matching request");

	// eviction only happens on a miss
	a_evict_miss: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_word.evicted |-> !out_word.hit)
		else $error("eviction reported on a hit");

endmodule

bind lfu_cache_table_unit lfuct_chk u_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.in_word   (in_word),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_word  (out_word)
);

// ----- tb/lfuct_checker.sv -----
// Scoreboard for the LFU cache table: watches both channels and the capacity port.
// Keeps its own copy of the table, predicts each result word and compares it.
// Depends on lfuct_pkg for the word types, codes and table geometry.
module lfuct_checker (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	input  logic                        in_ready,
	input  lfuct_pkg::in_word_t         in_word,
	input  logic                        out_valid,
	input  logic                        out_ready,
	input  lfuct_pkg::out_word_t        out_word,
	input  logic                        cfg_we,
	input  logic [lfuct_pkg::CAP_W-1:0] cfg_data,
	output int                          fail_count,
	output int                          words_pending
);
	timeunit 1ns;
	timeprecision 1ps;

	import lfuct_pkg::*;

	// shadow table
	logic                   tab_used [CAPACITY];
	logic [31:0]            tab_key  [CAPACITY];
	logic [31:0]            tab_data [CAPACITY];
	logic [COUNT_WIDTH-1:0] tab_hits [CAPACITY];
	int unsigned            tab_age  [CAPACITY];
	int                     tab_fill;
	logic [CAP_W-1:0]       cap_limit;

	out_word_t result_q [$];
	int        bad_words;
	int        outstanding;

	assign fail_count    = bad_words;
	assign words_pending = outstanding;

	// most recent entry gets age 0, younger ones shift back by one
	function automatic void bump_entry(int s);
		int unsigned r;
		r = tab_age[s];
		for (int i = 0; i < CAPACITY; i++)
			if (tab_used[i] && i != s && tab_age[i] < r)
				tab_age[i]++;
		tab_age[s] = 0;
		if (tab_hits[s] != COUNT_MAX)
			tab_hits[s]++;
	endfunction

	function automatic out_word_t lookup_and_update(in_word_t w);
		out_word_t   r;
		int          s;
		int          v;
		int          free_slot;
		int          lim;
		int unsigned vr;
		lim = (int'(cap_limit) > CAPACITY) ? CAPACITY : int'(cap_limit);
		s = -1;
		for (int i = 0; i < CAPACITY; i++)
			if (s < 0 && tab_used[i] && tab_key[i] == w.lookup_key)
				s = i;
		r = '0;
		r.hit = (s >= 0);
		if (w.action == ACT_GET) begin
			if (s >= 0) begin
				bump_entry(s);
				r.read_value = tab_data[s];
			end else begin
				r.read_value = MISS_VALUE;
			end
			return r;
		end
		if (lim == 0)
			return r;
		if (s >= 0) begin
			tab_data[s] = w.write_value;
			bump_entry(s);
			return r;
		end
		// full (or over a lowered limit): drop lowest count, oldest first
		if (tab_fill >= lim) begin
			v = -1;
			for (int i = 0; i < CAPACITY; i++) begin
				if (!tab_used[i])
					continue;
				if (v < 0 || tab_hits[i] < tab_hits[v] ||
					(tab_hits[i] == tab_hits[v] && tab_age[i] > tab_age[v]))
					v = i;
			end
			if (v >= 0) begin
				vr = tab_age[v];
				tab_used[v] = 1'b0;
				for (int i = 0; i < CAPACITY; i++)
					if (tab_used[i] && tab_age[i] > vr)
						tab_age[i]--;
				tab_fill--;
				r.evicted     = 1'b1;
				r.evicted_key = tab_key[v];
			end
		end
		free_slot = -1;
		for (int i = 0; i < CAPACITY; i++)
			if (free_slot < 0 && !tab_used[i])
				free_slot = i;
		if (free_slot >= 0) begin
			for (int i = 0; i < CAPACITY; i++)
				if (tab_used[i])
					tab_age[i]++;
			tab_used[free_slot] = 1'b1;
			tab_key[free_slot]  = w.lookup_key;
			tab_data[free_slot] = w.write_value;
			tab_hits[free_slot] = COUNT_WIDTH'(1);
			tab_age[free_slot]  = 0;
			tab_fill++;
		end
		return r;
	endfunction

	function automatic bit field_matches(string fname, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			$error("%s: expected %h, actual %h", fname, want, got);
			return 1'b0;
		end
		return 1'b1;
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		out_word_t want;
		bit        ok;
		if (!arst_n) begin
			for (int i = 0; i < CAPACITY; i++)
				tab_used[i] = 1'b0;
			tab_fill    = 0;
			cap_limit   = CAP_RESET;
			result_q.delete();
			bad_words   = 0;
			outstanding = 0;
		end else begin
			if (cfg_we)
				cap_limit = cfg_data;
			if (out_valid && out_ready) begin
				if (result_q.size() == 0) begin
					$error("result word %h with nothing pending", out_word);
					bad_words++;
				end else begin
					want = result_q.pop_front();
					ok = 1'b1;
					ok &= field_matches("hit", want.hit, out_word.hit);
					ok &= field_matches("read_value", want.read_value, out_word.read_value);
					ok &= field_matches("evicted", want.evicted, out_word.evicted);
					ok &= field_matches("evicted_key", want.evicted_key, out_word.evicted_key);
					if (!ok)
						bad_words++;
				end
			end
			if (in_valid && in_ready)
				result_q.push_back(lookup_and_update(in_word));
			outstanding = result_q.size();
		end
	end

endmodule

// ----- tb/tb_top.sv -----
// Top of the LFU cache table bench: clock, reset, request stimulus and verdict.
// Depends on lfuct_pkg, lfu_cache_table_unit and lfuct_checker.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import lfuct_pkg::*;

	localparam int POOL_SIZE = 24;
	localparam int PHASES = 10;
	localparam int PHASE_WORDS = 155;

	logic             clk = 1'b0;
	logic             arst_n;
	logic             in_valid;
	logic             in_ready;
	in_word_t         in_word;
	logic             out_valid;
	logic             out_ready;
	out_word_t        out_word;
	logic             cfg_we;
	logic [CAP_W-1:0] cfg_data;

	int fails;
	int pending;

	// no_idle: both sides run back to back (used for long stretches);
	// cur_cap tracks the last capacity written
	bit               no_idle;
	logic [CAP_W-1:0] cur_cap;
	logic [31:0]      key_pool [POOL_SIZE];

	lfu_cache_table_unit DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_word   (in_word),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_word  (out_word),
		.cfg_we    (cfg_we),
		.cfg_data  (cfg_data)
	);

	lfuct_checker u_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.in_word       (in_word),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.out_word      (out_word),
		.cfg_we        (cfg_we),
		.cfg_data      (cfg_data),
		.fail_count    (fails),
		.words_pending (pending)
	);

	// 2 ns period
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Hard stop; the slowest legal run is well under a third of this.
	initial begin
		#(3_000_000);
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// Result side: per word, hold ready low for a random stall length, then keep it high
	// until a word goes through. Only one drive per falling edge.
	initial begin : sink
		int stall;
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			stall = no_idle ? 0 : $urandom_range(0, 4);
			repeat (stall) begin
				@(negedge clk);
				out_ready <= 1'b0;
			end
			@(negedge clk);
			out_ready <= 1'b1;
			@(posedge clk);
			while (!out_valid)
				@(posedge clk);
		end
	end

	// One request word: random gap, then valid held until the block takes it.
	// valid is never dropped and raised in the same step: a zero gap just
	// swaps the payload at the next falling edge.
	task automatic put_word(logic act, logic [31:0] key, logic [31:0] val);
		in_word_t w;
		int       gap;
		w.action      = act;
		w.lookup_key  = key;
		w.write_value = val;
		gap = no_idle ? 0 : $urandom_range(0, 4);
		repeat (gap) begin
			@(negedge clk);
			in_valid <= 1'b0;
		end
		@(negedge clk);
		in_valid <= 1'b1;
		in_word  <= w;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
	endtask

	// Stop sending and let every pending result drain.
	task automatic settle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (6)
			@(negedge clk);
	endtask

	// Capacity is only touched with the block idle.
	task automatic set_capacity(logic [CAP_W-1:0] c);
		settle();
		@(negedge clk);
		cfg_we   <= 1'b1;
		cfg_data <= c;
		@(negedge clk);
		cfg_we   <= 1'b0;
		cur_cap = c;
	endtask

	// Keys mostly from a pool a bit larger than the capacity, so hits,
	// overwrites and evictions all show up; some fully random keys too.
	function automatic logic [31:0] pick_key();
		int span;
		span = ((int'(cur_cap) > CAPACITY) ? CAPACITY : int'(cur_cap)) + 4;
		if (span > POOL_SIZE)
			span = POOL_SIZE;
		if ($urandom_range(0, 9) == 0)
			return $urandom();
		return key_pool[$urandom_range(0, span - 1)];
	endfunction

	initial begin : stim
		logic [CAP_W-1:0] cap_plan [PHASES];
		logic             act;
		arst_n   = 1'b0;
		in_valid = 1'b0;
		in_word  = '0;
		cfg_we   = 1'b0;
		cfg_data = CAP_RESET;
		no_idle  = 1'b0;
		cur_cap  = CAP_RESET;

		key_pool[0] = 32'h8000_0000;
		key_pool[1] = 32'h7FFF_FFFF;
		key_pool[2] = 32'h0000_0000;
		key_pool[3] = 32'hFFFF_FFFF;
		key_pool[4] = 32'h0000_0001;
		for (int i = 5; i < POOL_SIZE; i++)
			key_pool[i] = $urandom();

		cap_plan = '{5'd16, 5'd3, 5'd31, 5'd1, 5'd8, 5'd0, 5'd17, 5'd5, 5'd2, 5'd16};

		repeat (9)
			@(negedge clk);
		arst_n <= 1'b1;

		// Recency tie-break: two entries with equal counts in 2 slots, the
		// first one touched last. The first new key must push out the older
		// one; the second new key then pushes out the count-1 newcomer.
		no_idle = 1'b1;
		set_capacity(5'd2);
		put_word(ACT_SET, 32'h1234_5678, 32'h0000_0011);
		put_word(ACT_SET, 32'h0BAD_F00D, 32'h0000_0022);
		put_word(ACT_GET, 32'h0BAD_F00D, $urandom());
		put_word(ACT_GET, 32'h1234_5678, $urandom());
		put_word(ACT_SET, 32'h5555_AAAA, 32'h0000_0033);
		put_word(ACT_SET, 32'hAAAA_5555, 32'h0000_0044);
		no_idle = 1'b0;

		// Directed: key/value extremes, hit and miss on both actions
		set_capacity(5'd16);
		put_word(ACT_GET, 32'h8000_0000, 32'h0000_0000);     // miss
		put_word(ACT_SET, 32'h8000_0000, 32'h7FFF_FFFF);
		put_word(ACT_SET, 32'h7FFF_FFFF, 32'h8000_0000);
		put_word(ACT_SET, 32'h0000_0000, 32'h0000_0000);
		put_word(ACT_SET, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		put_word(ACT_GET, 32'h8000_0000, 32'hFFFF_FFFF);
		put_word(ACT_GET, 32'h7FFF_FFFF, 32'h0000_0000);
		put_word(ACT_GET, 32'hFFFF_FFFF, 32'h0000_0000);     // hit that reads all ones
		put_word(ACT_SET, 32'h0000_0000, 32'h0000_1234);     // overwrite
		put_word(ACT_GET, 32'h0000_0000, 32'h0000_0000);

		// zero capacity: sets are dropped but still report a present key
		set_capacity(5'd0);
		put_word(ACT_SET, 32'h0000_0000, 32'h0000_0099);
		put_word(ACT_SET, 32'h0000_0042, 32'h0000_0042);
		put_word(ACT_GET, 32'h0000_0042, 32'h0000_0000);
		put_word(ACT_GET, 32'h0000_0000, 32'h0000_0000);

		// register above the table size acts as the full table
		set_capacity(5'd31);
		put_word(ACT_SET, 32'h0000_0042, 32'hDEAD_BEEF);

		// limit lowered under occupancy: each new key swaps one entry out
		set_capacity(5'd2);
		put_word(ACT_SET, 32'h0000_0077, 32'h0000_0077);
		put_word(ACT_SET, 32'h0000_0078, 32'h0000_0078);
		put_word(ACT_GET, 32'h0000_0077, 32'h0000_0000);

		// Random phases across a spread of capacities; some phases run
		// without idling, some stop halfway until the pipe is empty.
		for (int p = 0; p < PHASES; p++) begin
			set_capacity(cap_plan[p]);
			no_idle = (p % 4 == 3);
			for (int n = 0; n < PHASE_WORDS; n++) begin
				if (n == PHASE_WORDS / 2 && p % 3 == 0)
					settle();
				act = ($urandom_range(0, 99) < 45) ? ACT_SET : ACT_GET;
				put_word(act, pick_key(), $urandom());
			end
		end
		no_idle = 1'b0;

		// drain and give the verdict
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (10)
			@(negedge clk);
		if (fails == 0 && pending == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

// ----- files.f -----
rtl/core/lfuct_pkg.sv
rtl/core/lfuct_ctrl.sv
rtl/core/lfuct_dpath.sv
rtl/core/lfu_cache_table_unit.sv
rtl/core/lfuct_chk.sv
tb/lfuct_checker.sv
tb/tb_top.sv
